// File: rtl/tee_pkg.sv
// tee_pkg: shared types and constants for the tucker element evaluator
// used by tee_ctrl, tee_dp and the top level
`default_nettype none
package tee_pkg;
  localparam int MaxRank = 16;
  localparam int MaxDim = 64;
  localparam int RankW = $clog2(MaxRank);
  localparam int DimW = $clog2(MaxDim);
  localparam int CoreDepth = MaxRank * MaxRank * MaxRank;
  localparam int FactDepth = 3 * MaxDim * MaxRank;
  localparam int CoreAw = $clog2(CoreDepth);
  localparam int FactAw = $clog2(FactDepth);
  localparam int AccW = 64;

  typedef enum logic [1:0] {
    KIND_CORE = 2'd0,
    KIND_FACT = 2'd1,
    KIND_EVAL = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  localparam logic [1:0] REG_RANK0 = 2'd0;
  localparam logic [1:0] REG_RANK1 = 2'd1;
  localparam logic [1:0] REG_RANK2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_SAT, ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic issue;
    logic [RankW-1:0] j0;
    logic [RankW-1:0] j1;
    logic [RankW-1:0] j2;
    logic zero;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/tee_ram.sv
// tee_ram: generic simple dual port ram with registered read
// no dependencies
`default_nettype none
module tee_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/tee_ctrl.sv
// tee_ctrl: sequencer walking the core indices for one evaluation
// depends on tee_pkg
`default_nettype none
module tee_ctrl import tee_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire             empty_i,
  input  wire [RankW:0]   r0_i,
  input  wire [RankW:0]   r1_i,
  input  wire [RankW:0]   r2_i,
  input  wire             out_free_i,
  output cmd_t            cmd_o,
  output logic            done_o,
  output stat_t           stat_o
);
  localparam int DrainCycles = 6;
  state_e state_q, state_d;
  logic [RankW-1:0] j0_q, j0_d, j1_q, j1_d, j2_q, j2_d;
  logic [2:0] cnt_q, cnt_d;
  logic last0, last1, last2;

  assign last0 = ({1'b0, j0_q} == r0_i - 1'b1);
  assign last1 = ({1'b0, j1_q} == r1_i - 1'b1);
  assign last2 = ({1'b0, j2_q} == r2_i - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j0_q <= '0; j1_q <= '0; j2_q <= '0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      j0_q <= j0_d; j1_q <= j1_d; j2_q <= j2_d; cnt_q <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    j0_d = j0_q; j1_d = j1_q; j2_d = j2_q; cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.j0 = j0_q; cmd_o.j1 = j1_q; cmd_o.j2 = j2_q;
    done_o = 1'b0;
    stat_o.busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.clear = 1'b1;
          cmd_o.zero = empty_i;
          j0_d = '0; j1_d = '0; j2_d = '0; cnt_d = '0;
          state_d = empty_i ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (last2) begin
          j2_d = '0;
          if (last1) begin
            j1_d = '0;
            if (last0) state_d = ST_DRAIN;
            else j0_d = j0_q + 1'b1;
          end else j1_d = j1_q + 1'b1;
        end else j2_d = j2_q + 1'b1;
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'(DrainCycles - 1)) state_d = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          done_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> ({1'b0, j2_q} < r2_i))
    else $error("core index past rank");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == ST_OUT)
    else $error("done outside output state");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> state_q == ST_RUN)
    else $error("issue outside run");
endmodule
`default_nettype wire

// File: rtl/tee_dp.sv
// tee_dp: stores and multiply-accumulate pipeline
// depends on tee_pkg and tee_ram
`default_nettype none
module tee_dp import tee_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               core_we_i,
  input  wire [CoreAw-1:0]  core_waddr_i,
  input  wire [31:0]        core_wdata_i,
  input  wire               fact_we_i,
  input  wire [FactAw-1:0]  fact_waddr_i,
  input  wire [15:0]        fact_wdata_i,
  input  wire [DimW-1:0]    i0_i,
  input  wire [DimW-1:0]    i1_i,
  input  wire [DimW-1:0]    i2_i,
  input  cmd_t              cmd_i,
  output logic [31:0]       value_o,
  output logic              sat_o
);
  // one factor ram per mode so all three read together
  localparam int FmAw = DimW + RankW;
  logic [CoreAw-1:0] core_ra;
  logic [31:0] core_rd;
  logic [15:0] f_rd [3];
  logic [FmAw-1:0] f_ra [3];
  logic [RankW-1:0] jj [3];
  logic [DimW-1:0] ii [3];
  logic [3:0] v_q;
  logic signed [47:0] p1_q, p2_q, p3_q;
  logic signed [15:0] u1_q, u2_q, u2b_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0] val_q;
  logic sat_q;

  assign core_ra = {cmd_i.j0, cmd_i.j1, cmd_i.j2};
  assign jj[0] = cmd_i.j0; assign jj[1] = cmd_i.j1; assign jj[2] = cmd_i.j2;
  assign ii[0] = i0_i; assign ii[1] = i1_i; assign ii[2] = i2_i;

  tee_ram #(.Width(32), .Depth(CoreDepth)) u_core (
    .clk_i, .we_i(core_we_i), .waddr_i(core_waddr_i), .wdata_i(core_wdata_i),
    .raddr_i(core_ra), .rdata_o(core_rd));

  for (genvar m = 0; m < 3; m++) begin : g_f
    logic [FmAw-1:0] wa;
    logic we;
    assign f_ra[m] = {ii[m], jj[m]};
    assign wa = FmAw'(fact_waddr_i - FactAw'(m * MaxDim * MaxRank));
    assign we = fact_we_i && (fact_waddr_i >= FactAw'(m * MaxDim * MaxRank))
                && (fact_waddr_i < FactAw'((m + 1) * MaxDim * MaxRank));
    tee_ram #(.Width(16), .Depth(MaxDim * MaxRank)) u_f (
      .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(fact_wdata_i),
      .raddr_i(f_ra[m]), .rdata_o(f_rd[m]));
  end

  function automatic logic signed [47:0] rnd(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'sd16384;
    return 48'(y >>> 15);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[2:0], cmd_i.issue};
  end

  // stage 1: core*u0, 2: *u1, 3: *u2, 4: accumulate
  always_ff @(posedge clk_i) begin
    p1_q <= rnd(64'($signed(core_rd)) * 64'($signed(f_rd[0])));
    u1_q <= $signed(f_rd[1]);
    u2_q <= $signed(f_rd[2]);
    p2_q <= rnd(64'(p1_q) * 64'(u1_q));
    u2b_q <= u2_q;
    p3_q <= rnd(64'(p2_q) * 64'(u2b_q));
    if (cmd_i.clear) acc_q <= '0;
    else if (v_q[3]) acc_q <= acc_q + 64'(p3_q);
    if (cmd_i.zero) begin
      val_q <= '0; sat_q <= 1'b0;
    end else if (cmd_i.finish) begin
      if (acc_q > 64'sd2147483647) begin
        val_q <= 32'sh7fffffff; sat_q <= 1'b1;
      end else if (acc_q < -64'sd2147483648) begin
        val_q <= 32'sh80000000; sat_q <= 1'b1;
      end else begin
        val_q <= acc_q[31:0]; sat_q <= 1'b0;
      end
    end
  end

  assign value_o = val_q;
  assign sat_o = sat_q;
endmodule
`default_nettype wire

// File: rtl/tucker_element_evaluate.sv
// tucker_element_evaluate: top level of the tucker element evaluator
// depends on tee_pkg, tee_ctrl, tee_dp
// usage: s_axis items carry core writes, factor writes or element requests.
// writes give no result. a request walks r0*r1*r2 core
// entries (ranks clamped to 16), one per cycle through a three multiplier
// pipeline; the single read port of each store sets this pace.
// one request is in work at a time: s_axis_tready drops during an evaluation
// until its result moves into the m_axis register, and stays low while a
// finished result waits behind one still held there. writes go back to back.
// m_axis tdata holds the element value, tuser the saturation flag; the
// result holds until m_axis_tready. reset clears the ranks to 1 and the
// control; the stores are not cleared and must be written before use.
// apb registers: 0 rank_first, 1 rank_second, 2 rank_third at 4*i.
`default_nettype none
module tucker_element_evaluate import tee_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0], factor_select[3:2], index_a[9:4], index_b[15:10],
  // index_c[21:16], write_value[53:22], zero fill
  input  wire [55:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // element_value[31:0]
  output logic        m_axis_tuser,   // saturated
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [3:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] r_q [3];
  logic [RankW:0] re [3];
  kind_e kind;
  logic [1:0] sel;
  logic [5:0] ia, ib, ic;
  logic signed [31:0] wv;
  logic acc, empty, start, done;
  logic [15:0] fv;
  logic [DimW-1:0] i0_q, i1_q, i2_q;
  logic ovalid_q;
  cmd_t cmd;
  stat_t stat;
  logic [31:0] val;
  logic sat;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q[0] <= 5'd1; r_q[1] <= 5'd1; r_q[2] <= 5'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RANK0: r_q[0] <= pwdata[4:0];
        REG_RANK1: r_q[1] <= pwdata[4:0];
        REG_RANK2: r_q[2] <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_RANK0: prdata = {27'd0, r_q[0]};
      REG_RANK1: prdata = {27'd0, r_q[1]};
      REG_RANK2: prdata = {27'd0, r_q[2]};
      default: prdata = '0;
    endcase
  end
  for (genvar m = 0; m < 3; m++) begin : g_r
    assign re[m] = (r_q[m] > 5'(MaxRank)) ? (RankW+1)'(MaxRank) : r_q[m][RankW:0];
  end

  assign kind = kind_e'(s_axis_tdata[1:0]);
  assign sel = s_axis_tdata[3:2];
  assign ia = s_axis_tdata[9:4];
  assign ib = s_axis_tdata[15:10];
  assign ic = s_axis_tdata[21:16];
  assign wv = s_axis_tdata[53:22];
  assign s_axis_tready = !stat.busy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign start = acc && kind == KIND_EVAL;
  assign empty = (re[0] == 0) || (re[1] == 0) || (re[2] == 0);
  assign fv = (wv > 32'sd32767) ? 16'h7fff : (wv < -32'sd32768) ? 16'h8000 : wv[15:0];

  always_ff @(posedge clk_i) begin
    if (start) begin
      i0_q <= ia; i1_q <= ib; i2_q <= ic;
    end
  end

  tee_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .empty_i(empty),
    .r0_i(re[0]), .r1_i(re[1]), .r2_i(re[2]),
    .out_free_i(!ovalid_q), .cmd_o(cmd), .done_o(done), .stat_o(stat));

  tee_dp u_dp (
    .clk_i, .rst_ni,
    .core_we_i(acc && kind == KIND_CORE && ia < 6'(MaxRank) && ib < 6'(MaxRank)
               && ic < 6'(MaxRank)),
    .core_waddr_i({ia[RankW-1:0], ib[RankW-1:0], ic[RankW-1:0]}),
    .core_wdata_i(wv),
    .fact_we_i(acc && kind == KIND_FACT && sel != 2'd3 && ib < 6'(MaxRank)),
    .fact_waddr_i(FactAw'({sel, ia[DimW-1:0], ib[RankW-1:0]})),
    .fact_wdata_i(fv),
    .i0_i(i0_q), .i1_i(i1_q), .i2_i(i2_q),
    .cmd_i(cmd), .value_o(val), .sat_o(sat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      m_axis_tdata <= val; m_axis_tuser <= sat;
    end
  end
  assign m_axis_tvalid = ovalid_q;
endmodule
`default_nettype wire

// File: dv/tb.sv
// tb: self-checking testbench for tucker_element_evaluate
// depends on tee_pkg and the rtl top level; predicts element values from a local
// copy of the core and factor stores and checks every result on m_axis
`default_nettype none
module tb;
  import tee_pkg::*;

  typedef struct packed {
    logic [31:0] wv;
    logic [5:0]  c;
    logic [5:0]  b;
    logic [5:0]  a;
    logic [1:0]  sel;
    kind_e       kind;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } elem_t;

  localparam int CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         s_ready, m_valid, m_user, pready;
  wire  [31:0] m_data, prdata;

  tucker_element_evaluate uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  logic signed [31:0] core_mem [CoreDepth];
  logic signed [15:0] fact_mem [FactDepth];
  logic [4:0]         rank_q [3] = '{5'd1, 5'd1, 5'd1};

  item_t pending_q[$];
  elem_t elem_q[$];
  int    fails = 0;
  int    cycles = 0;
  int    src_idle = 0;
  int    dst_stall = 0;
  int    hold_cnt = 0;
  bit    want_hold = 0;
  bit    in_taken = 0;

  function automatic longint round_q15(longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic elem_t eval_element(logic [5:0] i0, logic [5:0] i1, logic [5:0] i2);
    longint acc, p;
    int     r0, r1, r2;
    elem_t  e;
    acc = 0;
    r0 = (rank_q[0] > MaxRank) ? MaxRank : rank_q[0];
    r1 = (rank_q[1] > MaxRank) ? MaxRank : rank_q[1];
    r2 = (rank_q[2] > MaxRank) ? MaxRank : rank_q[2];
    for (int j0 = 0; j0 < r0; j0++)
      for (int j1 = 0; j1 < r1; j1++)
        for (int j2 = 0; j2 < r2; j2++) begin
          p = core_mem[(j0 * MaxRank + j1) * MaxRank + j2];
          p = round_q15(p * longint'(fact_mem[i0 * MaxRank + j0]));
          p = round_q15(p * longint'(fact_mem[(MaxDim + i1) * MaxRank + j1]));
          p = round_q15(p * longint'(fact_mem[(2 * MaxDim + i2) * MaxRank + j2]));
          acc += p;
        end
    e.sat = 1'b0;
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      e.sat = 1'b1;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      e.sat = 1'b1;
    end
    e.value = acc[31:0];
    return e;
  endfunction

  // accepted items update the local stores; requests queue an expectation
  always @(posedge clk_i) begin
    item_t it;
    elem_t e;
    longint v;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tucker_element_evaluate: mismatch");
      $finish;
    end
    if (s_valid && s_ready) begin
      it = item_t'(s_data[53:0]);
      in_taken = 1;
      case (it.kind)
        KIND_CORE: if (it.a < MaxRank && it.b < MaxRank && it.c < MaxRank)
          core_mem[(it.a * MaxRank + it.b) * MaxRank + it.c] = it.wv;
        KIND_FACT: if (it.sel < 3 && it.b < MaxRank) begin
          v = longint'($signed(it.wv));
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          fact_mem[(it.sel * MaxDim + it.a) * MaxRank + it.b] = v[15:0];
        end
        KIND_EVAL: elem_q = {elem_q, eval_element(it.a, it.b, it.c)};
        default: ;
      endcase
    end
    if (m_valid && m_ready) begin
      if (elem_q.size() == 0) begin
        $error("result with nothing expected: element_value %h", m_data);
        fails++;
      end else begin
        e = elem_q.pop_front();
        if (m_data !== e.value) begin
          $error("element_value expected %h actual %h", e.value, m_data);
          fails++;
        end
        if (m_user !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, m_user);
          fails++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    bit go;
    if (rst_ni && (!s_valid || in_taken)) begin
      go = pending_q.size() > 0 && $urandom_range(99) >= src_idle;
      if (go) s_data <= {2'b00, pending_q.pop_front()};
      s_valid <= go;
    end
    in_taken = 0;
  end

  always @(negedge clk_i) begin
    if (want_hold) begin
      hold_cnt = 400;
      want_hold = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= rst_ni && ($urandom_range(99) >= dst_stall);
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [4:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {27'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    rank_q[idx] = val;
  endtask

  task automatic set_ranks(logic [4:0] r0, logic [4:0] r1, logic [4:0] r2);
    apb_write(REG_RANK0, r0);
    apb_write(REG_RANK1, r1);
    apb_write(REG_RANK2, r2);
  endtask

  task automatic push(kind_e k, int sel, int a, int b, int c, logic [31:0] wv);
    item_t it;
    it.kind = k; it.sel = 2'(sel); it.a = 6'(a); it.b = 6'(b); it.c = 6'(c);
    it.wv = wv;
    pending_q = {pending_q, it};
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_valid || elem_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mostly in-range writes and requests, some ignored indexes and kind 3;
  // requests stay on row 0 unless the ranks leave nothing to read
  function automatic item_t rand_item(bit any_row);
    item_t it;
    int    pick;
    it = item_t'(54'({$urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.kind = KIND_CORE;
      if ($urandom_range(9) > 0) begin
        it.a[5:4] = 2'b00; it.b[5:4] = 2'b00; it.c[5:4] = 2'b00;
      end
    end else if (pick < 70) begin
      it.kind = KIND_FACT;
      if ($urandom_range(9) > 0) begin
        it.b[5:4] = 2'b00;
        it.sel = 2'($urandom_range(2));
      end
      if ($urandom_range(1)) it.wv = {{16{it.wv[15]}}, it.wv[15:0]};
    end else if (pick < 95) begin
      it.kind = KIND_EVAL;
      if (!any_row) begin
        it.a = '0; it.b = '0; it.c = '0;
      end
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

  task automatic random_phase(int n, bit any_row);
    repeat (n) pending_q = {pending_q, rand_item(any_row)};
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_ranks(5'd1, 5'd1, 5'd1);
    push(KIND_CORE, 0, 0, 0, 0, 32'h7fffffff);
    push(KIND_FACT, 0, 0, 0, 0, 32'd40000);          // clamps high
    push(KIND_FACT, 1, 63, 0, 0, -32'sd40000);       // clamps low
    push(KIND_FACT, 2, 0, 0, 0, 32'h80000000);
    push(KIND_FACT, 1, 0, 0, 0, 32'h00007fff);
    push(KIND_FACT, 2, 63, 0, 0, 32'hffff8000);
    push(KIND_FACT, 0, 63, 0, 0, 32'd12345);
    push(KIND_CORE, 0, 16, 0, 0, 32'h12345678);      // ignored index
    push(KIND_CORE, 0, 0, 63, 63, 32'h12345678);
    push(KIND_FACT, 3, 0, 0, 0, 32'd1);              // ignored select
    push(KIND_FACT, 0, 0, 16, 0, 32'd1);             // ignored column
    push(KIND_FACT, 0, 0, 63, 0, 32'd1);
    push(KIND_NONE, 3, 63, 63, 63, 32'hffffffff);
    push(KIND_EVAL, 0, 0, 0, 0, 0);
    push(KIND_EVAL, 0, 0, 63, 0, 0);
    push(KIND_EVAL, 0, 0, 0, 63, 0);
    push(KIND_EVAL, 3, 63, 63, 63, 32'hffffffff);
    drain();

    // two large terms overflow in both directions
    set_ranks(5'd2, 5'd1, 5'd1);
    push(KIND_CORE, 0, 1, 0, 0, 32'h7fffffff);
    push(KIND_FACT, 0, 0, 1, 0, 32'h00007fff);
    push(KIND_FACT, 2, 0, 0, 0, 32'h00007fff);
    push(KIND_EVAL, 0, 0, 0, 0, 0);
    push(KIND_FACT, 1, 0, 0, 0, 32'hffff8000);
    push(KIND_EVAL, 0, 0, 0, 0, 0);
    drain();

    // a zero rank reads nothing, so any element may be asked for
    set_ranks(5'd0, 5'd3, 5'd2);
    src_idle = 60;
    random_phase(28, 1'b1);

    // rank above the limit walks 16 entries along the first mode
    set_ranks(5'd31, 5'd1, 5'd1);
    src_idle = 0; dst_stall = 60;
    for (int j = 0; j < MaxRank; j++) begin
      push(KIND_CORE, 0, j, 0, 0, $urandom);
      push(KIND_FACT, 0, 0, j, 0, $urandom_range(65535) - 32768);
    end
    random_phase(20, 1'b0);

    set_ranks(5'd2, 5'd2, 5'd2);
    src_idle = 0; dst_stall = 0;
    for (int j = 0; j < 8; j++)
      push(KIND_CORE, 0, j / 4, (j / 2) % 2, j % 2, $urandom);
    push(KIND_FACT, 1, 0, 1, 0, $urandom_range(65535) - 32768);
    push(KIND_FACT, 2, 0, 1, 0, $urandom_range(65535) - 32768);
    drain();
    src_idle = 31; dst_stall = 31;
    want_hold = 1;
    random_phase(25, 1'b0);

    if (fails == 0) begin
      $display("tucker_element_evaluate: match");
    end else begin
      $display("tucker_element_evaluate: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
